// File: rtl/core/hex27_shape_function_eval_assert.svh
// Assertion macros used by the shape function evaluator RTL.
`ifndef HEX27_SHAPE_FUNCTION_EVAL_ASSERT_SVH
`define HEX27_SHAPE_FUNCTION_EVAL_ASSERT_SVH

`ifndef SYNTHESIS
`define HEX27_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define HEX27_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HEX27_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HEX27_ASSERT_ALWAYS(lbl, cond)
`define HEX27_ASSERT_IMPLY(lbl, ante, cons)
`define HEX27_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/hex27_pkg.sv
// Types, constants and arithmetic helpers of the hex27 shape function evaluator.
`default_nettype none

package hex27_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int GUARD_BITS = 4;
    localparam int PREC       = FRAC_BITS + GUARD_BITS;
    localparam int COORD_W    = 16;
    localparam int CLAMP_W    = FRAC_BITS + 2;
    localparam int CMP_W      = ((COORD_W > CLAMP_W) ? COORD_W : CLAMP_W) + 1;
    localparam int SQ_W       = 2 * CLAMP_W;
    localparam int WIDE_W     = 2 * FRAC_BITS + 5;
    localparam int FAC_W      = PREC + 3;
    localparam int AB_W       = PREC + 4;
    localparam int PROD1_W    = 2 * FAC_W;
    localparam int PROD2_W    = AB_W + FAC_W;
    localparam int SH_N       = 2 * FRAC_BITS + 1 - PREC;
    localparam int SH_V       = 2 * PREC - FRAC_BITS;
    localparam int OUT_W      = 18;
    localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_W - 1));
    localparam int NODE_W     = 5;
    localparam int NODE_COUNT = 27;
    localparam int FIELD_COUNT = 10;

    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);

    localparam int F_VALUE = 0;
    localparam int F_D_R   = 1;
    localparam int F_D_S   = 2;
    localparam int F_D_T   = 3;
    localparam int F_D_RR  = 4;
    localparam int F_D_SS  = 5;
    localparam int F_D_TT  = 6;
    localparam int F_D_RS  = 7;
    localparam int F_D_ST  = 8;
    localparam int F_D_RT  = 9;

    typedef logic signed [CLAMP_W-1:0] t_clamp;
    typedef logic signed [FAC_W-1:0]   t_fac;
    typedef logic signed [AB_W-1:0]    t_ab;
    typedef logic signed [PROD1_W-1:0] t_prod1;
    typedef logic signed [PROD2_W-1:0] t_prod2;
    typedef logic signed [OUT_W-1:0]   t_out;

    typedef enum logic [1:0] {
        KIND_N,
        KIND_D,
        KIND_H
    } t_kind;

    typedef struct packed {
        t_kind kr;
        t_kind ks;
        t_kind kt;
    } t_fkind;

    typedef struct packed {
        t_fac n0;
        t_fac n1;
        t_fac n2;
        t_fac d0;
        t_fac d1;
        t_fac d2;
    } t_axis;

    typedef struct packed {
        t_fac n;
        t_fac d;
        t_fac h;
    } t_sel;

    // Base index per axis packed as {r, s, t}, two bits each.
    localparam logic [5:0] NODE_TABLE [NODE_COUNT] = '{
        6'b00_00_00, 6'b01_00_00, 6'b01_01_00, 6'b00_01_00,
        6'b00_00_01, 6'b01_00_01, 6'b01_01_01, 6'b00_01_01,
        6'b10_00_00, 6'b01_10_00, 6'b10_01_00, 6'b00_10_00,
        6'b10_00_01, 6'b01_10_01, 6'b10_01_01, 6'b00_10_01,
        6'b00_00_10, 6'b01_00_10, 6'b01_01_10, 6'b00_01_10,
        6'b10_00_10, 6'b01_10_10, 6'b10_01_10, 6'b00_10_10,
        6'b10_10_00, 6'b10_10_01, 6'b10_10_10
    };

    localparam t_fkind FIELD_KIND [FIELD_COUNT] = '{
        '{KIND_N, KIND_N, KIND_N},
        '{KIND_D, KIND_N, KIND_N},
        '{KIND_N, KIND_D, KIND_N},
        '{KIND_N, KIND_N, KIND_D},
        '{KIND_H, KIND_N, KIND_N},
        '{KIND_N, KIND_H, KIND_N},
        '{KIND_N, KIND_N, KIND_H},
        '{KIND_D, KIND_D, KIND_N},
        '{KIND_N, KIND_D, KIND_D},
        '{KIND_D, KIND_N, KIND_D}
    };

    function automatic t_clamp clamp_coord(input logic signed [COORD_W-1:0] x);
        logic signed [CMP_W-1:0] xe;
        logic signed [CMP_W-1:0] one;
        xe  = CMP_W'(x);
        one = CMP_W'(1) <<< FRAC_BITS;
        if (xe > one) begin
            xe = one;
        end else if (xe < -one) begin
            xe = -one;
        end
        return xe[CLAMP_W-1:0];
    endfunction

    function automatic t_axis axis_factors(input t_clamp x);
        logic signed [SQ_W-1:0]   sq2;
        logic signed [WIDE_W-1:0] sq;
        logic signed [WIDE_W-1:0] xs;
        logic signed [WIDE_W-1:0] half;
        logic signed [WIDE_W-1:0] one2;
        logic signed [WIDE_W-1:0] nv0;
        logic signed [WIDE_W-1:0] nv1;
        logic signed [WIDE_W-1:0] nv2;
        t_fac  xf;
        t_fac  onef;
        t_axis a;
        sq2  = x * x;
        sq   = WIDE_W'(sq2);
        xs   = WIDE_W'(x) <<< FRAC_BITS;
        half = WIDE_W'(1) <<< (SH_N - 1);
        one2 = WIDE_W'(1) <<< (2 * FRAC_BITS);
        nv0  = (sq - xs + half) >>> SH_N;
        nv1  = (sq + xs + half) >>> SH_N;
        nv2  = (((one2 - sq) <<< 1) + half) >>> SH_N;
        xf   = FAC_W'(x);
        onef = FAC_W'(1) <<< FRAC_BITS;
        a.n0 = nv0[FAC_W-1:0];
        a.n1 = nv1[FAC_W-1:0];
        a.n2 = nv2[FAC_W-1:0];
        a.d0 = ((xf <<< 1) - onef) <<< (GUARD_BITS - 1);
        a.d1 = ((xf <<< 1) + onef) <<< (GUARD_BITS - 1);
        a.d2 = -(xf <<< (GUARD_BITS + 1));
        return a;
    endfunction

    function automatic t_sel select_axis(input t_axis ax, input logic [1:0] idx);
        t_sel s;
        case (idx)
            2'd0: begin
                s.n = ax.n0;
                s.d = ax.d0;
                s.h = FAC_W'(1) <<< PREC;
            end
            2'd1: begin
                s.n = ax.n1;
                s.d = ax.d1;
                s.h = FAC_W'(1) <<< PREC;
            end
            2'd2: begin
                s.n = ax.n2;
                s.d = ax.d2;
                s.h = -(FAC_W'(1) <<< (PREC + 1));
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

    function automatic t_fac pick(input t_sel s, input t_kind k);
        t_fac v;
        case (k)
            KIND_N:  v = s.n;
            KIND_D:  v = s.d;
            KIND_H:  v = s.h;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_ab round_ab(input t_prod1 p);
        t_prod1 w;
        w = (p + (PROD1_W'(1) <<< (PREC - 1))) >>> PREC;
        return w[AB_W-1:0];
    endfunction

    function automatic t_out round_sat(input t_prod2 p);
        t_prod2 w;
        t_out   v;
        w = (p + (PROD2_W'(1) <<< (SH_V - 1))) >>> SH_V;
        if (w > PROD2_W'(OUT_MAX)) begin
            v = OUT_W'(OUT_MAX);
        end else if (w < PROD2_W'(OUT_MIN)) begin
            v = OUT_W'(OUT_MIN);
        end else begin
            v = w[OUT_W-1:0];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hex27_shape_function_eval.sv
// Top level of the triquadratic hex27 shape function evaluator.
// A point passes the input register and the axis factor bank; each node result then passes P0, P1, P2 and the output.
// The node sequencer gives one node result per cycle while the output is not stalled, 27 results per point.
// The next point is taken and held while the current one runs; its axis factors load as the last node issues.
// A stall on the output freezes the node counter and the pipeline stages; no result is lost or repeated.
// Reset is synchronous, active low, and clears all valid bits and the node counter.
`default_nettype none
`include "hex27_shape_function_eval_assert.svh"

module hex27_shape_function_eval (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [hex27_pkg::COORD_W-1:0]   i_coord_r,
    input  wire logic signed [hex27_pkg::COORD_W-1:0]   i_coord_s,
    input  wire logic signed [hex27_pkg::COORD_W-1:0]   i_coord_t,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [hex27_pkg::NODE_W-1:0]                o_node,
    output logic                                        o_last,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_value,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_r,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_s,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_t,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_rr,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_ss,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_tt,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_rs,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_st,
    output logic signed [hex27_pkg::OUT_W-1:0]          o_d_rt
);

    logic                       en;
    logic                       seq_last;
    logic                       bank_free;
    logic                       bank_load;
    logic                       in_xfer;

    logic                       r_f1_valid;
    hex27_pkg::t_clamp          r_f1_r;
    hex27_pkg::t_clamp          r_f1_s;
    hex27_pkg::t_clamp          r_f1_t;

    logic                       r_bank_valid;
    logic [hex27_pkg::NODE_W-1:0] r_cnt;
    hex27_pkg::t_axis           r_ax_r;
    hex27_pkg::t_axis           r_ax_s;
    hex27_pkg::t_axis           r_ax_t;

    logic                       r_p0_valid;
    logic                       r_p1_valid;
    logic                       r_p2_valid;
    logic                       r_out_valid;
    logic [hex27_pkg::NODE_W-1:0] r_p0_node;
    logic [hex27_pkg::NODE_W-1:0] r_p1_node;
    logic [hex27_pkg::NODE_W-1:0] r_p2_node;
    logic [hex27_pkg::NODE_W-1:0] r_out_node;

    hex27_pkg::t_sel            sel_r;
    hex27_pkg::t_sel            sel_s;
    hex27_pkg::t_sel            sel_t;
    logic [5:0]                 node_idx;

    hex27_pkg::t_fac            n_p0_a [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_fac            n_p0_b [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_fac            n_p0_c [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_fac            r_p0_a [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_fac            r_p0_b [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_fac            r_p0_c [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_prod1          r_p1_prod [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_fac            r_p1_c [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_prod2          r_p2_prod [hex27_pkg::FIELD_COUNT];
    hex27_pkg::t_out            r_out_val [hex27_pkg::FIELD_COUNT];

    assign en        = !r_out_valid || i_ready;
    assign seq_last  = (r_cnt == hex27_pkg::NODE_LAST);
    assign bank_free = !r_bank_valid || (en && seq_last);
    assign bank_load = r_f1_valid && bank_free;
    assign o_ready   = !r_f1_valid || bank_load;
    assign in_xfer   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_f1_valid <= 1'b1;
        end else if (bank_load) begin
            r_f1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_f1_r <= hex27_pkg::clamp_coord(i_coord_r);
            r_f1_s <= hex27_pkg::clamp_coord(i_coord_s);
            r_f1_t <= hex27_pkg::clamp_coord(i_coord_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_valid <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (bank_load) begin
                r_bank_valid <= 1'b1;
            end else if (bank_free) begin
                r_bank_valid <= 1'b0;
            end
            if (en && r_bank_valid) begin
                r_cnt <= seq_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bank_load) begin
            r_ax_r <= hex27_pkg::axis_factors(r_f1_r);
            r_ax_s <= hex27_pkg::axis_factors(r_f1_s);
            r_ax_t <= hex27_pkg::axis_factors(r_f1_t);
        end
    end

    always_comb begin
        node_idx = hex27_pkg::NODE_TABLE[r_cnt];
        sel_r    = hex27_pkg::select_axis(r_ax_r, node_idx[5:4]);
        sel_s    = hex27_pkg::select_axis(r_ax_s, node_idx[3:2]);
        sel_t    = hex27_pkg::select_axis(r_ax_t, node_idx[1:0]);
        for (int f = 0; f < hex27_pkg::FIELD_COUNT; f++) begin
            n_p0_a[f] = hex27_pkg::pick(sel_r, hex27_pkg::FIELD_KIND[f].kr);
            n_p0_b[f] = hex27_pkg::pick(sel_s, hex27_pkg::FIELD_KIND[f].ks);
            n_p0_c[f] = hex27_pkg::pick(sel_t, hex27_pkg::FIELD_KIND[f].kt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p0_valid  <= r_bank_valid;
            r_p1_valid  <= r_p0_valid;
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_node  <= r_cnt;
            r_p1_node  <= r_p0_node;
            r_p2_node  <= r_p1_node;
            r_out_node <= r_p2_node;
            for (int f = 0; f < hex27_pkg::FIELD_COUNT; f++) begin
                r_p0_a[f]    <= n_p0_a[f];
                r_p0_b[f]    <= n_p0_b[f];
                r_p0_c[f]    <= n_p0_c[f];
                r_p1_prod[f] <= r_p0_a[f] * r_p0_b[f];
                r_p1_c[f]    <= r_p0_c[f];
                r_p2_prod[f] <= hex27_pkg::round_ab(r_p1_prod[f]) * r_p1_c[f];
                r_out_val[f] <= hex27_pkg::round_sat(r_p2_prod[f]);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_node  = r_out_node;
    assign o_last  = (r_out_node == hex27_pkg::NODE_LAST);
    assign o_value = r_out_val[hex27_pkg::F_VALUE];
    assign o_d_r   = r_out_val[hex27_pkg::F_D_R];
    assign o_d_s   = r_out_val[hex27_pkg::F_D_S];
    assign o_d_t   = r_out_val[hex27_pkg::F_D_T];
    assign o_d_rr  = r_out_val[hex27_pkg::F_D_RR];
    assign o_d_ss  = r_out_val[hex27_pkg::F_D_SS];
    assign o_d_tt  = r_out_val[hex27_pkg::F_D_TT];
    assign o_d_rs  = r_out_val[hex27_pkg::F_D_RS];
    assign o_d_st  = r_out_val[hex27_pkg::F_D_ST];
    assign o_d_rt  = r_out_val[hex27_pkg::F_D_RT];

    `HEX27_ASSERT_ALWAYS(a_cnt_range, r_cnt <= hex27_pkg::NODE_LAST)
    `HEX27_ASSERT_IMPLY(a_idle_cnt, !r_bank_valid, r_cnt == '0)
    `HEX27_ASSERT_IMPLY(a_last_node, o_valid && o_last, o_node == hex27_pkg::NODE_LAST)
    `HEX27_ASSERT_NEXT(a_issue, en && r_bank_valid, r_p0_valid)
    `HEX27_ASSERT_NEXT(a_bank_fill, bank_load, r_bank_valid)

endmodule

`default_nettype wire
